>>> src/serial_command_line_matcher_top_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef SERIAL_COMMAND_LINE_MATCHER_TOP_MACROS_SVH
`define SERIAL_COMMAND_LINE_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/scl_pkg.sv
package scl_pkg;

    localparam int LINE_MAX_DEF = 20;
    localparam int SLOTS_DEF    = 12;
    localparam int NAME_LEN_DEF = 4;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [2:0] RSP_NONE  = 3'd0;
    localparam logic [2:0] RSP_ECHO  = 3'd1;
    localparam logic [2:0] RSP_BS    = 3'd2;
    localparam logic [2:0] RSP_BELL  = 3'd3;
    localparam logic [2:0] RSP_CRLF  = 3'd4;

    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_BLANK   = 2'd1;
    localparam logic [1:0] OUT_MATCH   = 2'd2;
    localparam logic [1:0] OUT_UNKNOWN = 2'd3;

endpackage

>>> src/serial_command_line_matcher_top.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | op, rx_byte, command_text
// out     | output    | out_valid/out_ready | response, echo_byte, control_char, dropped,
//         |           |                     | line_done, outcome, match_slot, table_full
//
// Byte, DEL and registration words: result registered in the cycle after accept.
// CR on a non-empty line: the table is scanned (one table RAM read per slot in use,
// compare on the registered read data, stop at the first match) before the result.
// Reset clears all control; the name table reads as empty through the fill count.
// in_ready is low while the table is scanned and while a result waits unaccepted
// with out_ready low.
`include "serial_command_line_matcher_top_macros.svh"

module serial_command_line_matcher_top #(
    parameter int LINE_MAX = scl_pkg::LINE_MAX_DEF,
    parameter int SLOTS    = scl_pkg::SLOTS_DEF,
    parameter int NAME_LEN = scl_pkg::NAME_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] command_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  response,
    output logic [7:0]  echo_byte,
    output logic        control_char,
    output logic        dropped,
    output logic        line_done,
    output logic [1:0]  outcome,
    output logic [3:0]  match_slot,
    output logic        table_full
);

    localparam int LEN_W  = $clog2(LINE_MAX + 1);
    localparam int SLOT_W = $clog2(SLOTS + 1);
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW     = 8 * NAME_LEN;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t            state_reg,     state_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic [NW-1:0]     head_reg,      head_next;
    logic [SLOT_W-1:0] slots_reg,     slots_next;
    logic [SLOT_W-1:0] issue_reg,     issue_next;
    logic              cmp_vld_reg,   cmp_vld_next;
    logic [AW-1:0]     cmp_idx_reg,   cmp_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        rsp_reg,       rsp_next;
    logic [7:0]        echo_reg,      echo_next;
    logic              ctrl_reg,      ctrl_next;
    logic              drop_reg,      drop_next;
    logic              done_reg,      done_next;
    logic [1:0]        outc_reg,      outc_next;
    logic [3:0]        slot_reg,      slot_next;
    logic              full_reg,      full_next;

    logic          in_fire;
    logic          out_fire;
    logic          issuing;
    logic          ram_we;
    logic [NW-1:0] ram_wdata;
    logic [NW-1:0] ram_rdata;
    logic          cmp_match;
    logic [63:0]   text_ext;
    logic          ended;
    logic [7:0]    c;
    logic [6:0]    slot_wide;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign issuing   = issue_reg < slots_reg;
    assign text_ext  = 64'(command_text);
    assign slot_wide = 7'(cmp_idx_reg);

    assign out_valid    = out_valid_reg;
    assign response     = rsp_reg;
    assign echo_byte    = echo_reg;
    assign control_char = ctrl_reg;
    assign dropped      = drop_reg;
    assign line_done    = done_reg;
    assign outcome      = outc_reg;
    assign match_slot   = slot_reg;
    assign table_full   = full_reg;

    always_comb
    begin
        ended     = 1'b0;
        c         = '0;
        ram_wdata = '0;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            c = (i < 4) ? text_ext[8*i +: 8] : 8'd0;
            if (c == 8'd0)
            begin
                ended = 1'b1;
            end
            ram_wdata[8*i +: 8] = ended ? 8'd0 : c;
        end
    end

    scl_ram #(
        .WIDTH (NW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slots_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    scl_cmp #(
        .NAME_LEN (NAME_LEN),
        .LEN_W    (LEN_W)
    ) u_cmp (
        .head  (head_reg),
        .len   (len_reg),
        .name  (ram_rdata),
        .match (cmp_match)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        slots_next     = slots_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        echo_next      = echo_reg;
        ctrl_next      = ctrl_reg;
        drop_next      = drop_reg;
        done_next      = done_reg;
        outc_next      = outc_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        ram_we         = 1'b0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rsp_next  = scl_pkg::RSP_NONE;
                    echo_next = '0;
                    ctrl_next = 1'b0;
                    drop_next = 1'b0;
                    done_next = 1'b0;
                    outc_next = scl_pkg::OUT_NONE;
                    slot_next = '0;
                    full_next = 1'b0;
                    out_valid_next = 1'b1;
                    if (op)
                    begin
                        if (slots_reg >= SLOT_W'(SLOTS))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            slots_next = slots_reg + 1'b1;
                        end
                    end
                    else if (rx_byte == scl_pkg::CH_CR)
                    begin
                        rsp_next  = scl_pkg::RSP_CRLF;
                        done_next = 1'b1;
                        if (len_reg == '0)
                        begin
                            outc_next = scl_pkg::OUT_BLANK;
                        end
                        else
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_SCAN;
                            issue_next     = '0;
                            cmp_vld_next   = 1'b0;
                        end
                    end
                    else if (rx_byte == scl_pkg::CH_DEL)
                    begin
                        if (len_reg != '0)
                        begin
                            len_next = len_reg - 1'b1;
                            rsp_next = scl_pkg::RSP_BS;
                        end
                        else
                        begin
                            rsp_next = scl_pkg::RSP_BELL;
                        end
                    end
                    else if (len_reg >= LEN_W'(LINE_MAX))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NAME_LEN; i++)
                        begin
                            if (len_reg == LEN_W'(i))
                            begin
                                head_next[8*i +: 8] = rx_byte;
                            end
                        end
                        len_next  = len_reg + 1'b1;
                        rsp_next  = scl_pkg::RSP_ECHO;
                        echo_next = rx_byte;
                        ctrl_next = rx_byte < scl_pkg::CH_SPACE;
                    end
                end
            end
            S_SCAN:
            begin
                cmp_vld_next = issuing;
                cmp_idx_next = issue_reg[AW-1:0];
                if (issuing)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (cmp_vld_reg && cmp_match)
                begin
                    outc_next      = scl_pkg::OUT_MATCH;
                    slot_next      = slot_wide[3:0];
                    state_next     = S_IDLE;
                    len_next       = '0;
                    cmp_vld_next   = 1'b0;
                    out_valid_next = 1'b1;
                end
                else if (!issuing)
                begin
                    outc_next      = scl_pkg::OUT_UNKNOWN;
                    state_next     = S_IDLE;
                    len_next       = '0;
                    cmp_vld_next   = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            head_reg      <= '0;
            slots_reg     <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            echo_reg      <= '0;
            ctrl_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            done_reg      <= 1'b0;
            outc_reg      <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            head_reg      <= head_next;
            slots_reg     <= slots_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
            rsp_reg       <= rsp_next;
            echo_reg      <= echo_next;
            ctrl_reg      <= ctrl_next;
            drop_reg      <= drop_next;
            done_reg      <= done_next;
            outc_reg      <= outc_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
        end
    end

    `SCL_ASSERT_NOW(a_scan_no_out, state_reg == S_SCAN, !out_valid_reg, "result shown during scan")
    `SCL_ASSERT_NOW(a_slots_bound, 1'b1, slots_reg <= SLOT_W'(SLOTS), "slot count over table size")
    `SCL_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(LINE_MAX), "line length over limit")
    `SCL_ASSERT_NEXT(a_cr_scan,
        in_fire && !op && rx_byte == scl_pkg::CH_CR && len_reg != '0,
        state_reg == S_SCAN && !out_valid_reg, "CR on non-empty line did not start scan")
    `SCL_ASSERT_NOW(a_match_crlf, out_valid_reg && outc_reg == scl_pkg::OUT_MATCH,
        rsp_reg == scl_pkg::RSP_CRLF && done_reg, "match without line end")

endmodule

>>> src/scl_ram.sv
module scl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/scl_cmp.sv
module scl_cmp #(
    parameter int NAME_LEN = 4,
    parameter int LEN_W    = 5
) (
    input  logic [8*NAME_LEN-1:0] head,
    input  logic [LEN_W-1:0]      len,
    input  logic [8*NAME_LEN-1:0] name,
    output logic                  match
);

    logic [7:0] a;
    logic [7:0] b;
    logic       alive;
    logic       ok;

    always_comb
    begin
        a     = '0;
        b     = '0;
        alive = 1'b1;
        ok    = 1'b1;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            a = (LEN_W'(i) < len) ? head[8*i +: 8] : 8'd0;
            b = name[8*i +: 8];
            if (alive)
            begin
                if (a != b)
                begin
                    ok = 1'b0;
                end
                if (a == 8'd0)
                begin
                    alive = 1'b0;
                end
            end
        end
        match = ok && (name[7:0] != 8'd0);
    end

endmodule

>>> verif/testbench.sv
module testbench;
    import scl_pkg::*;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;
    localparam int LINE_CAP     = LINE_MAX_DEF;
    localparam int TABLE_SLOTS  = SLOTS_DEF;
    localparam int NAME_CHARS   = NAME_LEN_DEF;
    localparam int WORD_TARGET  = 1100;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [2:0] response;
        logic [7:0] echo;
        logic       ctrl;
        logic       dropped;
        logic       done;
        logic [1:0] outcome;
        logic [3:0] slot;
        logic       full;
    } reply_t;

    class line_echo_tracker;
        logic [7:0]  head_chars [NAME_CHARS];
        int unsigned line_len;
        logic [31:0] names [TABLE_SLOTS];
        int unsigned names_used;
        reply_t      pending_replies [$];
        int unsigned fault_count;
        int unsigned reply_count;
        int unsigned matched_lines;
        int unsigned unknown_lines;
        int unsigned blank_lines;
        int unsigned dropped_bytes;
        int unsigned refused_names;

        function new();
            foreach (head_chars[i]) head_chars[i] = 8'h00;
            foreach (names[i]) names[i] = 32'h0;
            line_len      = 0;
            names_used    = 0;
            fault_count   = 0;
            reply_count   = 0;
            matched_lines = 0;
            unknown_lines = 0;
            blank_lines   = 0;
            dropped_bytes = 0;
            refused_names = 0;
        endfunction

        function logic [7:0] line_char(int unsigned pos);
            return (pos < line_len && pos < NAME_CHARS) ? head_chars[pos] : 8'h00;
        endfunction

        function bit slot_matches(int s);
            logic [7:0] a;
            logic [7:0] b;
            for (int i = 0; i < NAME_CHARS; i++)
            begin
                a = line_char(i);
                b = names[s][8*i +: 8];
                if (a != b)
                    return 1'b0;
                if (a == 8'h00)
                    return 1'b1;
            end
            return 1'b1;
        endfunction

        function reply_t next_reply(logic op_bit, logic [7:0] byte_val, logic [31:0] text);
            reply_t     r;
            logic       ended;
            logic [7:0] c;
            r = '0;
            if (op_bit == OP_REGISTER)
            begin
                if (names_used >= TABLE_SLOTS)
                    r.full = 1'b1;
                else
                begin
                    ended = 1'b0;
                    names[names_used] = 32'h0;
                    for (int i = 0; i < NAME_CHARS; i++)
                    begin
                        c = text[8*i +: 8];
                        if (c == 8'h00)
                            ended = 1'b1;
                        if (!ended)
                            names[names_used][8*i +: 8] = c;
                    end
                    names_used++;
                end
            end
            else if (byte_val == CH_CR)
            begin
                r.response = RSP_CRLF;
                r.done     = 1'b1;
                if (line_len == 0)
                    r.outcome = OUT_BLANK;
                else
                begin
                    r.outcome = OUT_UNKNOWN;
                    for (int s = 0; s < TABLE_SLOTS; s++)
                    begin
                        if (names[s][7:0] != 8'h00 && slot_matches(s))
                        begin
                            r.outcome = OUT_MATCH;
                            r.slot    = 4'(s);
                            break;
                        end
                    end
                end
                line_len = 0;
            end
            else if (byte_val == CH_DEL)
            begin
                if (line_len > 0)
                begin
                    line_len--;
                    r.response = RSP_BS;
                end
                else
                    r.response = RSP_BELL;
            end
            else if (line_len >= LINE_CAP)
                r.dropped = 1'b1;
            else
            begin
                if (line_len < NAME_CHARS)
                    head_chars[line_len] = byte_val;
                line_len++;
                r.response = RSP_ECHO;
                r.echo     = byte_val;
                r.ctrl     = (byte_val < CH_SPACE);
            end
            return r;
        endfunction

        function void note_word(logic op_bit, logic [7:0] byte_val, logic [31:0] text);
            reply_t r;
            r = next_reply(op_bit, byte_val, text);
            pending_replies.push_back(r);
            if (r.outcome == OUT_MATCH)
                matched_lines++;
            if (r.outcome == OUT_UNKNOWN)
                unknown_lines++;
            if (r.outcome == OUT_BLANK)
                blank_lines++;
            if (r.dropped)
                dropped_bytes++;
            if (r.full)
                refused_names++;
        endfunction

        function void compare_field(string label, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                fault_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            end
        endfunction

        function void check_word(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_replies.pop_front();
            reply_count++;
            compare_field("response", 8'(want.response), 8'(got.response));
            compare_field("echo_byte", want.echo, got.echo);
            compare_field("control_char", 8'(want.ctrl), 8'(got.ctrl));
            compare_field("dropped", 8'(want.dropped), 8'(got.dropped));
            compare_field("line_done", 8'(want.done), 8'(got.done));
            compare_field("outcome", 8'(want.outcome), 8'(got.outcome));
            compare_field("match_slot", 8'(want.slot), 8'(got.slot));
            compare_field("table_full", 8'(want.full), 8'(got.full));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [7:0]  rx_byte;
    logic [31:0] command_text;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  response;
    logic [7:0]  echo_byte;
    logic        control_char;
    logic        dropped;
    logic        line_done;
    logic [1:0]  outcome;
    logic [3:0]  match_slot;
    logic        table_full;

    line_echo_tracker board = new();
    int unsigned      words_sent = 0;
    bit               send_steady = 1'b0;

    serial_command_line_matcher_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .rx_byte      (rx_byte),
        .command_text (command_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .response     (response),
        .echo_byte    (echo_byte),
        .control_char (control_char),
        .dropped      (dropped),
        .line_done    (line_done),
        .outcome      (outcome),
        .match_slot   (match_slot),
        .table_full   (table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait(bit steady);
        return steady ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'($urandom_range(8'h61, 8'h64));
    endfunction

    function automatic logic [31:0] random_name();
        logic [31:0] t;
        int          len;
        case ($urandom_range(0, 9))
            0: t = $urandom();
            1: t = $urandom() & 32'hFFFF_FF00;
            default:
            begin
                t   = 32'h0;
                len = $urandom_range(1, NAME_CHARS);
                for (int i = 0; i < len; i++)
                    t[8*i +: 8] = pick_letter();
                if ($urandom_range(0, 2) == 0)
                    for (int i = len + 1; i < 4; i++)
                        t[8*i +: 8] = 8'($urandom_range(0, 255));
            end
        endcase
        return t;
    endfunction

    task automatic send_word(input logic op_bit, input logic [7:0] byte_val,
                             input logic [31:0] text);
        int gap;
        gap = draw_wait(send_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_bit;
        rx_byte      <= byte_val;
        command_text <= text;
        do @(posedge clk); while (!in_ready);
        board.note_word(op_bit, byte_val, text);
        words_sent++;
        if (words_sent % 90 == 0)
            send_steady = !send_steady;
        @(negedge clk);
    endtask

    task automatic type_byte(input logic [7:0] byte_val);
        send_word(OP_BYTE, byte_val, $urandom());
    endtask

    task automatic register_name(input logic [31:0] text);
        send_word(OP_REGISTER, 8'($urandom_range(0, 255)), text);
    endtask

    initial
    begin
        logic [31:0] known_names [$];
        logic [31:0] tgt;
        int          reg_count;
        int          pick;
        int          len;
        int          variant;
        bit          drained;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_BYTE;
        rx_byte      = 8'h00;
        command_text = 32'h0;
        drained      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        type_byte(CH_DEL);
        type_byte(CH_CR);
        register_name(32'h706c_6568);
        register_name(32'hFFFF_FF00);
        register_name(32'hE463_0061);
        known_names = '{32'h706c_6568, 32'hFFFF_FF00, 32'hE463_0061};
        reg_count = 3;
        type_byte(8'h68);
        type_byte(8'h65);
        type_byte(8'h6c);
        type_byte(8'h70);
        type_byte(8'hFF);
        type_byte(CH_CR);
        type_byte(8'h61);
        type_byte(8'h00);
        type_byte(8'h1F);
        type_byte(CH_CR);
        type_byte(8'h78);
        type_byte(8'h79);
        type_byte(CH_DEL);
        type_byte(CH_CR);

        while (words_sent < WORD_TARGET)
        begin
            if (!drained && words_sent >= WORD_TARGET / 2)
            begin
                // hold the input until every pending result has come back
                in_valid <= 1'b0;
                while (board.pending_replies.size() != 0) @(posedge clk);
                @(negedge clk);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < (reg_count < TABLE_SLOTS ? 12 : 3))
            begin
                tgt = random_name();
                register_name(tgt);
                if (reg_count < TABLE_SLOTS)
                begin
                    known_names.push_back(tgt);
                    reg_count++;
                end
            end
            else if (pick < 55)
            begin
                tgt = known_names[$urandom_range(0, known_names.size() - 1)];
                len = 0;
                while (len < NAME_CHARS && tgt[8*len +: 8] != 8'h00)
                    len++;
                variant = $urandom_range(0, 5);
                if (variant == 5)
                begin
                    type_byte(pick_letter());
                    type_byte(CH_DEL);
                end
                if (variant == 4 && len > 0)
                    len--;
                for (int i = 0; i < len; i++)
                    type_byte(tgt[8*i +: 8]);
                if (variant == 3)
                    repeat ($urandom_range(1, 4)) type_byte(pick_letter());
                type_byte(CH_CR);
            end
            else if (pick < 63)
            begin
                repeat ($urandom_range(18, 24))
                begin
                    if ($urandom_range(0, 9) == 0)
                        type_byte(CH_DEL);
                    else
                        type_byte(8'($urandom_range(33, 126)));
                end
                type_byte(CH_CR);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 4) == 0)
                        type_byte(8'($urandom_range(0, 255)));
                    else
                        type_byte(pick_letter());
                end
                type_byte(CH_CR);
            end
            else
                repeat ($urandom_range(1, 5)) type_byte(8'($urandom_range(0, 255)));
        end

        in_valid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d words: %0d matched, %0d unknown, %0d blank lines, %0d dropped bytes",
                 words_sent, board.matched_lines, board.unknown_lines, board.blank_lines,
                 board.dropped_bytes);
        $display("Refused %0d registrations; checked %0d results with %0d mismatches",
                 board.refused_names, board.reply_count, board.fault_count);
        if (board.fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        int stall;
        bit steady;
        bit held;
        stall     = 0;
        steady    = 1'b0;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                board.check_word({response, echo_byte, control_char, dropped, line_done,
                                  outcome, match_slot, table_full});
                stall = draw_wait(steady);
                if (!held && board.reply_count == HOLD_AFTER)
                begin
                    // back the matcher up against a stalled output
                    stall = HOLD_CYCLES;
                    held  = 1'b1;
                end
                if (board.reply_count % 70 == 0)
                    steady = !steady;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run stopped at the cycle limit", $time);
        $display("FAILURE");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/scl_pkg.sv
src/scl_ram.sv
src/scl_cmp.sv
src/serial_command_line_matcher_top.sv
verif/testbench.sv
